// ===== sv/ale_pkg.sv =====
// Shared types, codes and constants of the array list engine.
package ale_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned DefDepth = 64;

  typedef enum logic [1:0] {
    KindAppend  = 2'd0,
    KindRemove  = 2'd1,
    KindReverse = 2'd2,
    KindDump    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StRange = 2'd2,
    StEmpty = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SIdle    = 2'd0,
    SRemove  = 2'd1,
    SReverse = 2'd2,
    SDump    = 2'd3
  } state_e;

  typedef struct packed {
    kind_e                   kind;
    logic signed [DataW-1:0] value;
    logic [AddrW-1:0]        index;
  } in_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] element;
    logic [AddrW-1:0]        position;
    logic [CntW-1:0]         count;
    status_e                 status;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] ra_addr;
    logic [AddrW-1:0] rb_addr;
  } mem_req_t;

  typedef struct packed {
    logic [DataW-1:0] ra_data;
    logic [DataW-1:0] rb_data;
  } mem_rsp_t;

endpackage

// ===== sv/ale_mem.sv =====
// Element store: one write port, two registered read ports.
module ale_mem import ale_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output mem_rsp_t rsp_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] ra_q;
  logic [DataW-1:0] rb_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    ra_q <= mem[req_i.ra_addr[AW-1:0]];
    rb_q <= mem[req_i.rb_addr[AW-1:0]];
  end

  assign rsp_o.ra_data = ra_q;
  assign rsp_o.rb_data = rb_q;

endmodule

// ===== sv/ale_ctrl.sv =====
// Sequencer: count, operation walks over the store, result register.
module ale_ctrl import ale_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  in_i,
  output logic      busy_o,
  output logic      strobe_o,
  output out_word_t result_o,
  output mem_req_t  mem_req_o,
  input  mem_rsp_t  mem_rsp_i
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  p_q, p_d;
  logic             rv_q, rv_d;
  logic [AddrW-1:0] raddr_q, raddr_d;
  logic [AddrW-1:0] i_q, i_d;
  logic [AddrW-1:0] j_q, j_d;
  logic [AddrW-1:0] jw_q, jw_d;
  logic             phase_q, phase_d;
  logic             pend_q, pend_d;
  logic [DataW-1:0] tmp_q, tmp_d;
  logic             strobe_q, strobe_d;
  out_word_t        res_q, res_d;
  mem_req_t         req;

  logic accept, p_lt, i_lt_j, dump_last, idx_ok, full, two_plus;

  assign accept    = start_i && (state_q == SIdle);
  assign p_lt      = p_q < cnt_q;
  assign i_lt_j    = i_q < j_q;
  assign dump_last = rv_q && ((CntW'(raddr_q) + CntW'(1)) == cnt_q);
  assign idx_ok    = CntW'(in_i.index) < cnt_q;
  assign full      = cnt_q >= CntW'(Depth);
  assign two_plus  = cnt_q >= CntW'(2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          unique case (in_i.kind)
            KindAppend:  state_d = SIdle;
            KindRemove:  state_d = idx_ok ? SRemove : SIdle;
            KindReverse: state_d = two_plus ? SReverse : SIdle;
            KindDump:    state_d = (cnt_q != '0) ? SDump : SIdle;
            default:     state_d = SIdle;
          endcase
        end
      end
      SRemove:  if (!p_lt) state_d = SIdle;
      SReverse: if (!phase_q && !i_lt_j) state_d = SIdle;
      SDump:    if (dump_last) state_d = SIdle;
      default:  state_d = SIdle;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q;
    p_d      = p_q;
    rv_d     = rv_q;
    raddr_d  = raddr_q;
    i_d      = i_q;
    j_d      = j_q;
    jw_d     = jw_q;
    phase_d  = phase_q;
    pend_d   = pend_q;
    tmp_d    = tmp_q;
    strobe_d = 1'b0;
    res_d    = '0;
    req      = '0;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          unique case (in_i.kind)
            KindAppend: begin
              strobe_d   = 1'b1;
              res_d.last = 1'b1;
              if (full) begin
                res_d.status = StFull;
              end else begin
                req.we    = 1'b1;
                req.waddr = cnt_q[AddrW-1:0];
                req.wdata = in_i.value;
                cnt_d     = cnt_q + CntW'(1);
              end
            end
            KindRemove: begin
              if (idx_ok) begin
                p_d  = CntW'(in_i.index) + CntW'(1);
                rv_d = 1'b0;
              end else begin
                strobe_d     = 1'b1;
                res_d.last   = 1'b1;
                res_d.status = StRange;
              end
            end
            KindReverse: begin
              if (two_plus) begin
                i_d     = '0;
                j_d     = AddrW'(cnt_q - CntW'(1));
                phase_d = 1'b0;
                pend_d  = 1'b0;
              end else begin
                strobe_d   = 1'b1;
                res_d.last = 1'b1;
              end
            end
            KindDump: begin
              if (cnt_q != '0) begin
                p_d  = '0;
                rv_d = 1'b0;
              end else begin
                strobe_d     = 1'b1;
                res_d.last   = 1'b1;
                res_d.status = StEmpty;
              end
            end
            default: ;
          endcase
        end
      end
      SRemove: begin
        rv_d = 1'b0;
        if (p_lt) begin
          req.ra_addr = p_q[AddrW-1:0];
          rv_d        = 1'b1;
          raddr_d     = p_q[AddrW-1:0];
          p_d         = p_q + CntW'(1);
        end
        if (rv_q) begin
          req.we    = 1'b1;
          req.waddr = raddr_q - AddrW'(1);
          req.wdata = mem_rsp_i.ra_data;
        end
        if (!p_lt) begin
          cnt_d      = cnt_q - CntW'(1);
          strobe_d   = 1'b1;
          res_d.last = 1'b1;
        end
      end
      SReverse: begin
        if (!phase_q) begin
          if (pend_q) begin
            req.we    = 1'b1;
            req.waddr = jw_q;
            req.wdata = tmp_q;
            pend_d    = 1'b0;
          end
          if (i_lt_j) begin
            req.ra_addr = i_q;
            req.rb_addr = j_q;
            phase_d     = 1'b1;
          end else begin
            strobe_d   = 1'b1;
            res_d.last = 1'b1;
          end
        end else begin
          // low slot takes the high word now, high slot gets the saved word next
          req.we    = 1'b1;
          req.waddr = i_q;
          req.wdata = mem_rsp_i.rb_data;
          tmp_d     = mem_rsp_i.ra_data;
          jw_d      = j_q;
          pend_d    = 1'b1;
          i_d       = i_q + AddrW'(1);
          j_d       = j_q - AddrW'(1);
          phase_d   = 1'b0;
        end
      end
      SDump: begin
        rv_d = 1'b0;
        if (p_lt) begin
          req.ra_addr = p_q[AddrW-1:0];
          rv_d        = 1'b1;
          raddr_d     = p_q[AddrW-1:0];
          p_d         = p_q + CntW'(1);
        end
        if (rv_q) begin
          strobe_d       = 1'b1;
          res_d.element  = mem_rsp_i.ra_data;
          res_d.position = raddr_q;
          res_d.last     = dump_last;
        end
      end
      default: ;
    endcase
    res_d.count = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      cnt_q    <= '0;
      rv_q     <= 1'b0;
      phase_q  <= 1'b0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rv_q     <= rv_d;
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    raddr_q <= raddr_d;
    i_q     <= i_d;
    j_q     <= j_d;
    jw_q    <= jw_d;
    tmp_q   <= tmp_d;
    res_q   <= res_d;
  end

  assign busy_o    = state_q != SIdle;
  assign strobe_o  = strobe_q;
  assign result_o  = res_q;
  assign mem_req_o = req;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("element count above capacity");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> (CntW'(req.waddr) < CntW'(Depth)))
    else $error("store write beyond capacity");

  a_rev_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SReverse && phase_q) |-> i_lt_j)
    else $error("reverse swap with crossed pointers");

  a_mid_only_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_d && !res_d.last) |-> (state_q == SDump))
    else $error("non-final word outside dump");

  a_accept_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || strobe_q))
    else $error("accepted word left no trace");
`endif

endmodule

// ===== sv/array_list_engine.sv =====
// Array list engine top level: fixed-capacity list of signed 32-bit words.
// Append, failed remove, short reverse and empty dump: result in the cycle after start is taken.
// Remove at index k shifts the later elements down; reverse swaps pairs; both hold busy.
// Dump: one result per cycle, read through the registered store port, busy until the last.
// Results are never stalled; reset clears the count and control, store contents persist.
module array_list_engine import ale_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  in_i,
  output logic      busy_o,
  output logic      strobe_o,
  output out_word_t result_o
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;

  ale_ctrl #(
    .Depth(Depth)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .in_i      (in_i),
    .busy_o    (busy_o),
    .strobe_o  (strobe_o),
    .result_o  (result_o),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp)
  );

  ale_mem #(
    .Depth(Depth)
  ) u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

endmodule

// ===== verif/ale_checker.sv =====
// Checker for the array list engine: tracks the list and compares every result word.
`timescale 1ns / 100ps

module ale_checker import ale_pkg::*; #(
  parameter int unsigned Depth = DefDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  in_word_t  in_i,
  input  logic      strobe_i,
  input  out_word_t result_i,
  output int        err_count_o,
  output int        pending_o
);

  logic signed [DataW-1:0] list_mem [Depth];
  int unsigned             list_len;
  out_word_t               expected_q [$];
  int                      err_count = 0;

  task automatic log_error(input string what, input out_word_t want, input out_word_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] %s: expected elem=%0d pos=%0d cnt=%0d st=%0d last=%0b", $time, what,
               want.element, want.position, want.count, want.status, want.last);
      $display("[%0t] %s:   actual elem=%0d pos=%0d cnt=%0d st=%0d last=%0b", $time, what,
               got.element, got.position, got.count, got.status, got.last);
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (expected_q.size() == 0) begin
      log_error("unexpected result word", '0, got);
    end else begin
      want = expected_q.pop_front();
      if (got.element !== want.element || got.position !== want.position ||
          got.count !== want.count || got.status !== want.status ||
          got.last !== want.last) begin
        log_error("result mismatch", want, got);
      end
    end
  endtask

  // Applies one command to the tracked list and queues the words it produces.
  task automatic apply_list_op(input in_word_t cmd);
    out_word_t               r;
    logic signed [DataW-1:0] tmp;
    int unsigned             j;
    r        = '0;
    r.status = StOk;
    r.last   = 1'b1;
    case (cmd.kind)
      KindAppend: begin
        if (list_len >= Depth) begin
          r.status = StFull;
        end else begin
          list_mem[list_len] = cmd.value;
          list_len++;
        end
        r.count = list_len[CntW-1:0];
        expected_q.push_back(r);
      end
      KindRemove: begin
        if (cmd.index >= list_len) begin
          r.status = StRange;
        end else begin
          for (j = cmd.index + 1; j < list_len; j++) list_mem[j-1] = list_mem[j];
          list_len--;
        end
        r.count = list_len[CntW-1:0];
        expected_q.push_back(r);
      end
      KindReverse: begin
        for (j = 0; j < list_len / 2; j++) begin
          tmp                     = list_mem[j];
          list_mem[j]             = list_mem[list_len-1-j];
          list_mem[list_len-1-j]  = tmp;
        end
        r.count = list_len[CntW-1:0];
        expected_q.push_back(r);
      end
      default: begin
        if (list_len == 0) begin
          r.status = StEmpty;
          expected_q.push_back(r);
        end else begin
          for (j = 0; j < list_len; j++) begin
            r.element  = list_mem[j];
            r.position = j[AddrW-1:0];
            r.count    = list_len[CntW-1:0];
            r.last     = (j == list_len - 1);
            expected_q.push_back(r);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (strobe_i) check_word(result_i);
      if (start_i && !busy_i) apply_list_op(in_i);
    end
    err_count_o <= err_count;
    pending_o   <= expected_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the array list engine testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import ale_pkg::*;

  localparam int unsigned Depth         = DefDepth;
  localparam int unsigned RandomItems   = 400;
  localparam int unsigned WatchdogLimit = 1000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  in_word_t  in_word;
  logic      busy;
  logic      strobe;
  out_word_t result;
  int        err_count;
  int        pending;
  int        idle_cycles = 0;

  int unsigned list_len;   // shadow length, only for shaping stimulus
  logic        grow_mode;
  int unsigned burst_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  array_list_engine #(.Depth(Depth)) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start_i (start),
    .in_i    (in_word),
    .busy_o  (busy),
    .strobe_o(strobe),
    .result_o(result)
  );

  ale_checker #(.Depth(Depth)) i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_i     (busy),
    .in_i       (in_word),
    .strobe_i   (strobe),
    .result_i   (result),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (r < 5) begin
      burst_left = $urandom_range(30, 10);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 82) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic send_word(input kind_e k, input logic [DataW-1:0] v,
                           input logic [AddrW-1:0] idx);
    in_word_t    w;
    int unsigned gap;
    w.kind  = k;
    w.value = v;
    w.index = idx;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    if (k == KindAppend && list_len < Depth) list_len++;
    if (k == KindRemove && idx < list_len) list_len--;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_word();
    int unsigned        r;
    kind_e              k;
    logic [AddrW-1:0]   idx;
    if (grow_mode && list_len == Depth && $urandom_range(3) == 0) grow_mode = 1'b0;
    if (!grow_mode && list_len == 0 && $urandom_range(2) == 0) grow_mode = 1'b1;
    r = $urandom_range(99);
    if (grow_mode) begin
      if (r < 80)      k = KindAppend;
      else if (r < 88) k = KindRemove;
      else if (r < 94) k = KindReverse;
      else             k = KindDump;
    end else begin
      if (r < 55)      k = KindRemove;
      else if (r < 70) k = KindAppend;
      else if (r < 80) k = KindReverse;
      else             k = KindDump;
    end
    if (list_len > 0 && $urandom_range(99) < 85) idx = AddrW'($urandom_range(list_len - 1));
    else idx = AddrW'($urandom_range(Depth - 1));
    send_word(k, pick_value(), idx);
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_word    <= '0;
    list_len   = 0;
    grow_mode  = 1'b1;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corners
    send_word(KindDump, 32'h0, 6'd0);
    send_word(KindRemove, 32'h0, 6'd0);
    send_word(KindRemove, 32'hffff_ffff, 6'd63);
    send_word(KindReverse, 32'h0, 6'd0);
    // single element, then value extremes
    send_word(KindAppend, 32'h8000_0000, 6'd0);
    send_word(KindReverse, 32'h0, 6'd0);
    send_word(KindDump, 32'h0, 6'd0);
    send_word(KindAppend, 32'h7fff_ffff, 6'd63);
    send_word(KindAppend, 32'h0000_0000, 6'd0);
    send_word(KindAppend, 32'hffff_ffff, 6'd0);
    send_word(KindDump, 32'h0, 6'd0);
    send_word(KindReverse, 32'h0, 6'd0);
    send_word(KindDump, 32'h0, 6'd0);
    send_word(KindRemove, 32'h0, 6'd4);
    send_word(KindRemove, 32'h0, 6'd3);
    send_word(KindRemove, 32'h0, 6'd0);
    send_word(KindAppend, 32'h5555_aaaa, 6'd0);
    send_word(KindRemove, 32'h0, 6'd1);
    send_word(KindReverse, 32'h0, 6'd0);
    send_word(KindDump, 32'h0, 6'd0);

    repeat (RandomItems) random_word();

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Depth + 10) @(posedge clk);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
